/* rtl/bb3_pkg.sv */
// Package with shared types and constants of the 3x3 box blur.
`default_nettype none
package bb3_pkg;
   localparam int CH_W  = 8;
   localparam int PIX_W = 24;
   localparam int SUM_W = 12;
   localparam int NUM_W = 13;
   localparam int DEN_W = 5;
   localparam int FW_W  = 11;
   localparam int FH_W  = 16;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] HEIGHT_RESET = 16'd480;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_SUM   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;
endpackage
`default_nettype wire

/* rtl/box_blur_3x3_rgb_core.sv */
// Top level of the streaming 3x3 RGB box blur with its register port.
//
// Channel  Direction  Transfer when                 Contents
// req      in         req_tvalid & req_tready       pixel, drain command in tuser
// rsp      out        rsp_tvalid & rsp_tready       blurred pixel, tlast on frame end
// csr      in         csr_psel & penable & pready   frame_width, frame_height
//
// A transfer that is ignored leaves the block idle; any other passes through the line store
// read, the window shift and the neighborhood sum, and one that makes a result goes on
// through the divider and the load of the output register.
// The line store holds no reset and needs no clearing pass.
// Reset clears the counters, the window and the registers to 640 by 480.
// A result waits in the output register; a second result holds the block until it is taken.
`default_nettype none
module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  wire logic        req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // blur_red, blur_green, blur_blue
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PW  = bb3_pkg::PIX_W;
   localparam int HW  = bb3_pkg::FH_W;
   localparam int CH  = bb3_pkg::CH_W;
   localparam int SW  = bb3_pkg::SUM_W;

   bb3_pkg::state_type state_ff, state_in;

   logic [bb3_pkg::FW_W-1:0] fw_ff;
   logic [HW-1:0]            fh_ff;
   logic [CW:0]              w_eff;
   logic [HW-1:0]            h_eff;

   logic [CW:0]   in_col_ff, in_col_in, in_col_w;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [CW:0]   out_col_ff, out_col_in, out_col_w;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic [CW+1:0] lag_ff, lag_in;
   logic [PW-1:0] win_ff [9];
   logic [PW-1:0] win_in [9];
   logic [PW-1:0] px_ff, px_in;
   logic          last_ff, last_in;
   logic [CH-1:0] res_ff [3];
   logic [CH-1:0] res_in [3];
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          mem_rd;
   logic          mem_wr;
   logic [2*PW-1:0] mem_q;

   bb3_pkg::div_req_type div_req [3];
   logic                 div_done [3];
   logic [CH-1:0]        div_q [3];

   logic [SW-1:0] sum [3];
   logic [3:0]    cnt;
   logic          use_r0, use_r2, use_c0, use_c2;
   logic          frame_done;
   logic [HW:0]   out_row_p1;
   logic [CW+1:0] out_col_p1;
   logic          csr_wr;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= bb3_pkg::WIDTH_RESET;
         fh_ff <= bb3_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == bb3_pkg::REG_WIDTH) begin
            fw_ff <= csr_pwdata[bb3_pkg::FW_W-1:0];
         end else begin
            fh_ff <= csr_pwdata[HW-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == bb3_pkg::REG_HEIGHT) begin
         csr_prdata = {16'b0, fh_ff};
      end else begin
         csr_prdata = {21'b0, fw_ff};
      end
   end

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(fw_ff);
      end
      h_eff = (fh_ff == '0) ? HW'(1) : fh_ff;
   end

   assign in_col_w  = (in_col_ff >= w_eff) ? '0 : in_col_ff;
   assign out_col_w = (out_col_ff >= w_eff) ? '0 : out_col_ff;

   assign req_tready = (state_ff == bb3_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign mem_rd     = accept;
   assign mem_wr     = (state_ff == bb3_pkg::ST_SHIFT);

   bb3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (2 * PW)
   ) u_line (
      .clock   (clock),
      .rd_en   (mem_rd),
      .rd_addr (in_col_w[CW-1:0]),
      .rd_data (mem_q),
      .wr_en   (mem_wr),
      .wr_addr (in_col_ff[CW-1:0]),
      .wr_data ({mem_q[PW-1:0], px_ff})
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      bb3_divider u_div (
         .clock (clock),
         .reset (reset),
         .req   (div_req[g]),
         .done  (div_done[g]),
         .quot  (div_q[g])
      );
   end

   // Neighborhood sums over the cells that lie inside the frame.
   assign out_row_p1 = {1'b0, out_row_ff} + (HW+1)'(1);
   assign out_col_p1 = {1'b0, out_col_ff} + (CW+2)'(1);
   assign use_r0 = (out_row_ff != '0);
   assign use_r2 = !(out_row_p1 >= {1'b0, h_eff});
   assign use_c0 = (out_col_ff != '0);
   assign use_c2 = !(out_col_p1 >= {1'b0, w_eff});
   assign frame_done = !use_c2 ? !use_r2 : (out_row_ff >= h_eff);

   always_comb begin
      logic rk;
      logic ck;
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
      end
      cnt = (4'd1 + 4'(use_r0) + 4'(use_r2)) * (4'd1 + 4'(use_c0) + 4'(use_c2));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rk = (r == 1) || (r == 0 && use_r0) || (r == 2 && use_r2);
            ck = (c == 1) || (c == 0 && use_c0) || (c == 2 && use_c2);
            if (rk && ck) begin
               sum[0] = sum[0] + SW'(win_ff[r*3+c][7:0]);
               sum[1] = sum[1] + SW'(win_ff[r*3+c][15:8]);
               sum[2] = sum[2] + SW'(win_ff[r*3+c][23:16]);
            end
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      lag_in      = lag_ff;
      px_in       = px_ff;
      last_in     = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      for (int ch = 0; ch < 3; ch++) begin
         res_in[ch]        = res_ff[ch];
         div_req[ch].start = 1'b0;
         div_req[ch].numer = {sum[ch], 1'b0} + bb3_pkg::NUM_W'(cnt);
         div_req[ch].denom = {cnt, 1'b0};
      end
      case (state_ff)
         bb3_pkg::ST_IDLE: begin
            if (accept) begin
               in_col_in  = in_col_w;
               out_col_in = out_col_w;
               if (req_tuser == bb3_pkg::CMD_PIXEL) begin
                  px_in = req_tdata;
                  if (in_row_ff < h_eff) begin
                     state_in = bb3_pkg::ST_SHIFT;
                  end
               end else begin
                  px_in = '0;
                  if (!(in_row_ff < h_eff)) begin
                     state_in = bb3_pkg::ST_SHIFT;
                  end
               end
            end
         end
         bb3_pkg::ST_SHIFT: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3+0] = win_ff[r*3+1];
               win_in[r*3+1] = win_ff[r*3+2];
            end
            win_in[2] = mem_q[2*PW-1:PW];
            win_in[5] = mem_q[PW-1:0];
            win_in[8] = px_ff;
            if (in_col_ff + (CW+1)'(1) >= w_eff) begin
               in_col_in = '0;
               if (in_row_ff < h_eff) begin
                  in_row_in = in_row_ff + HW'(1);
               end
            end else begin
               in_col_in = in_col_ff + (CW+1)'(1);
            end
            if (lag_ff <= {1'b0, w_eff} + (CW+2)'(1)) begin
               lag_in = lag_ff + (CW+2)'(1);
            end
            state_in = bb3_pkg::ST_SUM;
         end
         bb3_pkg::ST_SUM: begin
            if (lag_ff < {1'b0, w_eff} + (CW+2)'(2)) begin
               state_in = bb3_pkg::ST_IDLE;
            end else begin
               for (int ch = 0; ch < 3; ch++) begin
                  div_req[ch].start = 1'b1;
               end
               lag_in  = {1'b0, w_eff} + (CW+2)'(1);
               last_in = !use_r2 && !use_c2;
               if (frame_done) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
                  lag_in     = '0;
               end else if (!use_c2) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + HW'(1);
               end else begin
                  out_col_in = out_col_ff + (CW+1)'(1);
               end
               state_in = bb3_pkg::ST_DIV;
            end
         end
         bb3_pkg::ST_DIV: begin
            if (div_done[0] & div_done[1] & div_done[2]) begin
               for (int ch = 0; ch < 3; ch++) begin
                  res_in[ch] = div_q[ch];
               end
               state_in = bb3_pkg::ST_OUT;
            end
         end
         bb3_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[2], res_ff[1], res_ff[0]};
               rsp_last_in  = last_ff;
               state_in     = bb3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bb3_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bb3_pkg::ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         lag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         lag_ff       <= lag_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
      px_ff       <= px_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int ch = 0; ch < 3; ch++) begin
         res_ff[ch] <= res_in[ch];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule
`default_nettype wire

/* rtl/bb3_line_mem.sv */
// Line store memory holding the upper and middle rows side by side.
`default_nettype none
module bb3_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/bb3_divider.sv */
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module bb3_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bb3_pkg::div_req_type      req,
   output logic                           done,
   output logic [bb3_pkg::CH_W-1:0]       quot
);
   localparam int NW = bb3_pkg::NUM_W;
   localparam int DW = bb3_pkg::DEN_W;

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NW-1]};
      if (req.start) begin
         num_in  = req.numer;
         den_in  = req.denom;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff[bb3_pkg::CH_W-1:0];
endmodule
`default_nettype wire
